>>> design/bdld_pkg.sv
package bdld_pkg;

	// Fixed field widths
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned BCD_W   = 4;
	localparam int unsigned LATCH_W = 2;

	// Divide by ten through a reciprocal: q = (v * RECIP10) >> RECIP_SHIFT,
	// exact for every 16-bit v
	localparam int unsigned    RECIP_SHIFT = 19;
	localparam logic [15:0]    RECIP10     = 16'd52429;
	localparam int unsigned    PROD_W      = 32;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [BCD_W-1:0]   bcd_t;
	typedef logic [LATCH_W-1:0] latch_t;

	// Result payload
	typedef struct packed {
		bcd_t   bcd_code;
		latch_t latch_index;
		logic   last;
	} result_t;

endpackage

>>> design/bdld_if.sv
// Value request channel
interface bdld_value_if;
	logic               valid;
	logic               ready;
	bdld_pkg::value_t   value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// Digit result channel
interface bdld_result_if;
	logic               valid;
	logic               ready;
	bdld_pkg::bcd_t     bcd_code;
	bdld_pkg::latch_t   latch_index;
	logic               last;

	modport source (output valid, output bcd_code, output latch_index, output last,
		input ready);
	modport sink   (input valid, input bcd_code, input latch_index, input last,
		output ready);
endinterface

>>> design/bdld_div_stage.sv
// One decimal place: strips the lowest digit of the running quotient
module bdld_div_stage #(
	parameter int unsigned DIGITS = 3,
	parameter int unsigned POS    = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  bdld_pkg::value_t              up_quot,
	input  logic [DIGITS-1:0][3:0]        up_digs,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output bdld_pkg::value_t              dn_quot,
	output logic [DIGITS-1:0][3:0]        dn_digs
);

	logic [bdld_pkg::PROD_W-1:0] prod;
	bdld_pkg::value_t            quot;
	bdld_pkg::bcd_t              rem;
	logic [DIGITS-1:0][3:0]      digs;

	logic                        vld_q;
	bdld_pkg::value_t            quot_q;
	logic [DIGITS-1:0][3:0]      digs_q;

	// Reciprocal multiply, then remainder by shift and subtract
	always_comb begin
		prod = bdld_pkg::PROD_W'(up_quot) * bdld_pkg::PROD_W'(bdld_pkg::RECIP10);
		quot = bdld_pkg::value_t'(prod >> bdld_pkg::RECIP_SHIFT);
		rem  = bdld_pkg::BCD_W'(up_quot - (quot << 3) - (quot << 1));
		digs = up_digs;
		digs[DIGITS-1-POS] = rem;
	end

	assign up_ready = !vld_q || dn_ready;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			quot_q <= quot;
			digs_q <= digs;
		end
	end

	assign dn_valid = vld_q;
	assign dn_quot  = quot_q;
	assign dn_digs  = digs_q;

endmodule

>>> design/bcd_digit_latch_driver_core.sv
// Channel   Dir   Payload                              Handshake
// value_ch  in    value[15:0]                          valid/ready
// digit_ch  out   bcd_code[3:0], latch_index[1:0], last valid/ready
//
// Path from request to first digit: input register, one divide-by-ten
// stage per digit, output serialiser; the next value loads as the last
// digit is taken. One digit per cycle leaves while digit_ch.ready is high.
// Reset clears the valid bits and cnt_q; payload registers are not reset.
// Back-pressure ripples stage by stage; nothing is dropped or repeated.
module bcd_digit_latch_driver_core #(
	parameter int unsigned DIGITS = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bdld_value_if.sink           value_ch,
	bdld_result_if.source        digit_ch
);

	localparam int unsigned CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	// Input register
	logic                        vld_s1;
	bdld_pkg::value_t            value_s1;
	logic                        rdy_s1;

	// Chain between divide stages
	logic                        ch_valid [DIGITS+1];
	logic                        ch_ready [DIGITS+1];
	bdld_pkg::value_t            ch_quot  [DIGITS+1];
	logic [DIGITS-1:0][3:0]      ch_digs  [DIGITS+1];

	// Serialiser
	logic                        ser_vld_q;
	logic [DIGITS-1:0][3:0]      ser_digs_q;
	logic [CW-1:0]               cnt_q;
	logic                        ser_last;
	logic                        ser_ready;
	bdld_pkg::result_t           res;

	assign rdy_s1         = !vld_s1 || ch_ready[0];
	assign value_ch.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= value_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && value_ch.valid) begin
			value_s1 <= value_ch.value;
		end
	end

	assign ch_valid[0] = vld_s1;
	assign ch_quot[0]  = value_s1;
	assign ch_digs[0]  = '0;

	// One stage per decimal place, lowest place first
	for (genvar k = 0; k < DIGITS; k++) begin : g_div
		bdld_div_stage #(
			.DIGITS (DIGITS),
			.POS    (k)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (ch_valid[k]),
			.up_ready (ch_ready[k]),
			.up_quot  (ch_quot[k]),
			.up_digs  (ch_digs[k]),
			.dn_valid (ch_valid[k+1]),
			.dn_ready (ch_ready[k+1]),
			.dn_quot  (ch_quot[k+1]),
			.dn_digs  (ch_digs[k+1])
		);
	end

	// Serialiser: emits the held digits most significant first
	assign ser_last           = (cnt_q == CW'(DIGITS - 1));
	assign ser_ready          = !ser_vld_q || (digit_ch.ready && ser_last);
	assign ch_ready[DIGITS]   = ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			cnt_q     <= '0;
		end else if (ser_ready) begin
			ser_vld_q <= ch_valid[DIGITS];
			cnt_q     <= '0;
		end else if (digit_ch.ready) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ser_ready && ch_valid[DIGITS]) begin
			ser_digs_q <= ch_digs[DIGITS];
		end
	end

	// Result fields
	always_comb begin
		res.bcd_code    = ser_digs_q[cnt_q];
		res.latch_index = bdld_pkg::LATCH_W'(cnt_q);
		res.last        = ser_last;
	end

	assign digit_ch.valid       = ser_vld_q;
	assign digit_ch.bcd_code    = res.bcd_code;
	assign digit_ch.latch_index = res.latch_index;
	assign digit_ch.last        = res.last;

endmodule
